// ===== design/rwmf_pkg.sv =====
// Shared types, constants and compare helpers for the 3x3 RGB median/mean filter.
`default_nettype none
package rwmf_pkg;

  localparam int unsigned WIN_SIDE  = 3;
  localparam int unsigned WIN_SIZE  = WIN_SIDE * WIN_SIDE;
  localparam int unsigned CHAN_W    = 8;
  localparam int unsigned NUM_CHAN  = 3;
  localparam int unsigned PIX_W     = CHAN_W * NUM_CHAN;
  localparam int unsigned CNT_W     = 4;
  localparam int unsigned SUM_W     = 12;
  localparam int unsigned RECIP_W   = 16;
  localparam int unsigned PROD_W    = SUM_W + RECIP_W;
  // floor(x / 10) == (x * 52429) >> 19 for every weighted sum of 8-bit values
  localparam logic [RECIP_W-1:0] MEAN_RECIP = 16'd52429;
  localparam int unsigned MEAN_SHIFT = 19;
  localparam int unsigned CENTER_IDX = WIN_SIZE / 2;

  localparam logic MODE_MEDIAN = 1'b0;
  localparam logic MODE_MEAN   = 1'b1;

  typedef logic [WIN_SIZE-1:0][CHAN_W-1:0] chan_win_t;
  typedef logic [WIN_SIDE-1:0][CHAN_W-1:0] trio_t;

  typedef struct packed {
    logic en0;
    logic en1;
    logic en2;
    logic en3;
  } pipe_ctl_t;

  // ascending sort of three values, element 0 is the smallest
  function automatic trio_t sort3(input logic [CHAN_W-1:0] a,
                                  input logic [CHAN_W-1:0] b,
                                  input logic [CHAN_W-1:0] c);
    logic [CHAN_W-1:0] x, y, z, t;
    trio_t res;
    x = a;
    y = b;
    z = c;
    if (x > y) begin
      t = x; x = y; y = t;
    end
    if (y > z) begin
      t = y; y = z; z = t;
    end
    if (x > y) begin
      t = x; x = y; y = t;
    end
    res[0] = x;
    res[1] = y;
    res[2] = z;
    return res;
  endfunction

  function automatic logic [CHAN_W-1:0] max2(input logic [CHAN_W-1:0] a,
                                             input logic [CHAN_W-1:0] b);
    return (a > b) ? a : b;
  endfunction

  function automatic logic [CHAN_W-1:0] min2(input logic [CHAN_W-1:0] a,
                                             input logic [CHAN_W-1:0] b);
    return (a < b) ? a : b;
  endfunction

  function automatic logic [CHAN_W-1:0] med3(input logic [CHAN_W-1:0] a,
                                             input logic [CHAN_W-1:0] b,
                                             input logic [CHAN_W-1:0] c);
    return max2(min2(a, b), min2(max2(a, b), c));
  endfunction

endpackage
`default_nettype wire

// ===== design/rwmf_cell.sv =====
// One window pixel cell: loads a new pixel or takes its right neighbor's pixel.
`default_nettype none
module rwmf_cell (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        shift_en_i,
  input  wire logic                        load_en_i,
  input  wire logic [rwmf_pkg::PIX_W-1:0]  nbr_i,
  input  wire logic [rwmf_pkg::PIX_W-1:0]  load_i,
  output logic      [rwmf_pkg::PIX_W-1:0]  pix_d_o,
  output logic      [rwmf_pkg::PIX_W-1:0]  pix_q_o
);

  logic [rwmf_pkg::PIX_W-1:0] pix_q, pix_d;

  always_comb begin
    pix_d = pix_q;
    if (load_en_i) begin
      pix_d = load_i;
    end else if (shift_en_i) begin
      pix_d = nbr_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pix_q <= '0;
    end else begin
      pix_q <= pix_d;
    end
  end

  assign pix_d_o = pix_d;
  assign pix_q_o = pix_q;

endmodule
`default_nettype wire

// ===== design/rwmf_chan.sv =====
// Per-channel filter pipeline: median-of-nine network and weighted mean over four stages.
`default_nettype none
module rwmf_chan (
  input  wire logic                         clk_i,
  input  wire rwmf_pkg::pipe_ctl_t          ctl_i,
  input  wire logic                         mode_i,
  input  wire rwmf_pkg::chan_win_t          win_i,
  output logic      [rwmf_pkg::CHAN_W-1:0]  res_o
);

  localparam int unsigned SW = rwmf_pkg::SUM_W;

  rwmf_pkg::chan_win_t                  win0_q;
  logic                                 mode0_q, mode1_q, mode2_q;
  rwmf_pkg::trio_t [rwmf_pkg::WIN_SIDE-1:0] rows1_q, rows1_d;
  logic [SW-1:0]                        sum1_q, sum1_d;
  logic [rwmf_pkg::CHAN_W-1:0]          lo2_q, mid2_q, hi2_q;
  logic [rwmf_pkg::PROD_W-1:0]          prod2_q;
  logic [rwmf_pkg::CHAN_W-1:0]          res3_q, res3_d;

  always_comb begin
    sum1_d = SW'(win0_q[rwmf_pkg::CENTER_IDX]);
    for (int i = 0; i < int'(rwmf_pkg::WIN_SIZE); i++) begin
      sum1_d = sum1_d + SW'(win0_q[i]);
    end
    for (int r = 0; r < int'(rwmf_pkg::WIN_SIDE); r++) begin
      rows1_d[r] = rwmf_pkg::sort3(win0_q[r*3], win0_q[r*3+1], win0_q[r*3+2]);
    end
  end

  always_comb begin
    if (mode2_q == rwmf_pkg::MODE_MEAN) begin
      res3_d = prod2_q[rwmf_pkg::MEAN_SHIFT +: rwmf_pkg::CHAN_W];
    end else begin
      res3_d = rwmf_pkg::med3(lo2_q, mid2_q, hi2_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en0) begin
      win0_q  <= win_i;
      mode0_q <= mode_i;
    end
    if (ctl_i.en1) begin
      rows1_q <= rows1_d;
      sum1_q  <= sum1_d;
      mode1_q <= mode0_q;
    end
    if (ctl_i.en2) begin
      lo2_q   <= rwmf_pkg::max2(rwmf_pkg::max2(rows1_q[0][0], rows1_q[1][0]), rows1_q[2][0]);
      mid2_q  <= rwmf_pkg::med3(rows1_q[0][1], rows1_q[1][1], rows1_q[2][1]);
      hi2_q   <= rwmf_pkg::min2(rwmf_pkg::min2(rows1_q[0][2], rows1_q[1][2]), rows1_q[2][2]);
      prod2_q <= rwmf_pkg::PROD_W'(sum1_q) * rwmf_pkg::PROD_W'(rwmf_pkg::MEAN_RECIP);
      mode2_q <= mode1_q;
    end
    if (ctl_i.en3) begin
      res3_q <= res3_d;
    end
  end

  assign res_o = res3_q;

endmodule
`default_nettype wire

// ===== design/rgb_window_median_mean_filter.sv =====
// Top level of the 3x3 RGB window filter: window cells, group control and output pipeline.
//
//  channel | direction | request fields
//  s_axis  | in        | tdata: red, green, blue (8 b each); tuser: full_reload
//  m_axis  | out       | tdata: red, green, blue (8 b each)
//  cfg     | in        | cfg_wdata_i: mode (0 median, 1 weighted mean)
//
// One pixel request accepted per cycle while s_axis_tready_o is high. A result leaves once
// the last pixel of a group has passed the four-stage channel pipeline (capture, sort, merge, select).
// Reset clears the window to zero, the group counter and the mode.
// An output stall fills the four stages in turn; s_axis_tready_o drops only
// when all four hold results.
`default_nettype none
module rgb_window_median_mean_filter (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  input  wire logic [rwmf_pkg::PIX_W-1:0]  s_axis_tdata_i,   // red_in, green_in, blue_in
  input  wire logic                        s_axis_tuser_i,   // full_reload
  output logic                             m_axis_tvalid_o,
  input  wire logic                        m_axis_tready_i,
  output logic      [rwmf_pkg::PIX_W-1:0]  m_axis_tdata_o,   // red_out, green_out, blue_out
  input  wire logic                        cfg_we_i,
  input  wire logic                        cfg_wdata_i
);

  localparam int unsigned SIDE = rwmf_pkg::WIN_SIDE;
  localparam int unsigned CW   = rwmf_pkg::CNT_W;

  logic                 mode_q;
  logic [CW-1:0]        cnt_q, cnt_d;
  logic                 full_q, full_d;
  logic                 v0_q, v1_q, v2_q, v3_q;
  logic                 acc, first, full_now, last;
  logic [CW-1:0]        cnt_inc;
  rwmf_pkg::pipe_ctl_t  ctl;

  logic [rwmf_pkg::WIN_SIZE-1:0][rwmf_pkg::PIX_W-1:0] win_d, win_q;

  assign ctl.en3 = !v3_q || m_axis_tready_i;
  assign ctl.en2 = !v2_q || ctl.en3;
  assign ctl.en1 = !v1_q || ctl.en2;
  assign ctl.en0 = !v0_q || ctl.en1;

  assign s_axis_tready_o = ctl.en0;
  assign acc      = s_axis_tvalid_i && s_axis_tready_o;
  assign first    = (cnt_q == '0);
  assign full_now = first ? s_axis_tuser_i : full_q;
  assign cnt_inc  = cnt_q + CW'(1);
  assign last     = full_now ? (cnt_inc == CW'(rwmf_pkg::WIN_SIZE)) : (cnt_inc == CW'(SIDE));

  always_comb begin
    cnt_d  = cnt_q;
    full_d = full_q;
    if (acc) begin
      full_d = full_now;
      cnt_d  = last ? '0 : cnt_inc;
    end
  end

  for (genvar r = 0; r < SIDE; r++) begin : g_row
    for (genvar c = 0; c < SIDE; c++) begin : g_col
      logic shift_en, load_en;
      assign shift_en = acc && first && !s_axis_tuser_i && (c < SIDE - 1);
      assign load_en  = acc && ((full_now && cnt_q == CW'(r * SIDE + c)) ||
                                (!full_now && c == SIDE - 1 && cnt_q == CW'(r)));
      rwmf_cell u_cell (
        .clk_i      (clk_i),
        .rst_ni     (rst_ni),
        .shift_en_i (shift_en),
        .load_en_i  (load_en),
        .nbr_i      (win_q[r * SIDE + ((c < SIDE - 1) ? c + 1 : c)]),
        .load_i     (s_axis_tdata_i),
        .pix_d_o    (win_d[r * SIDE + c]),
        .pix_q_o    (win_q[r * SIDE + c])
      );
    end
  end

  for (genvar k = 0; k < rwmf_pkg::NUM_CHAN; k++) begin : g_chan
    rwmf_pkg::chan_win_t chan_win;
    for (genvar i = 0; i < rwmf_pkg::WIN_SIZE; i++) begin : g_tap
      assign chan_win[i] = win_d[i][k * rwmf_pkg::CHAN_W +: rwmf_pkg::CHAN_W];
    end
    rwmf_chan u_chan (
      .clk_i  (clk_i),
      .ctl_i  (ctl),
      .mode_i (mode_q),
      .win_i  (chan_win),
      .res_o  (m_axis_tdata_o[k * rwmf_pkg::CHAN_W +: rwmf_pkg::CHAN_W])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= rwmf_pkg::MODE_MEDIAN;
      cnt_q  <= '0;
      full_q <= 1'b0;
      v0_q   <= 1'b0;
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      v3_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        mode_q <= cfg_wdata_i;
      end
      cnt_q  <= cnt_d;
      full_q <= full_d;
      if (ctl.en0) begin
        v0_q <= acc && last;
      end
      if (ctl.en1) begin
        v1_q <= v0_q;
      end
      if (ctl.en2) begin
        v2_q <= v1_q;
      end
      if (ctl.en3) begin
        v3_q <= v2_q;
      end
    end
  end

  assign m_axis_tvalid_o = v3_q;

`ifndef SYNTH
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q < CW'(rwmf_pkg::WIN_SIZE))
    else $error("group counter out of range");

  a_col_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !full_q |-> cnt_q < CW'(SIDE))
    else $error("column group counter out of range");

  a_v0_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v0_q && !$past(v0_q)) |-> $past(acc && last))
    else $error("result started without a completed group");

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> (v0_q && v1_q && v2_q && v3_q && !m_axis_tready_i))
    else $error("input stalled with room in the pipeline");
`endif

endmodule
`default_nettype wire

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for the 3x3 RGB window median / weighted-mean filter.
module tb;

  localparam int unsigned WATCHDOG_LIMIT = 5000;
  localparam int unsigned DRAIN_CYCLES   = 10;
  localparam int unsigned MEAN_DIV       = 10;
  localparam int unsigned PHASE_ITEMS    = 220;
  localparam int unsigned NUM_PHASES     = 8;
  localparam int unsigned MAX_REPORTS    = 60;

  localparam int unsigned NCH  = rwmf_pkg::NUM_CHAN;
  localparam int unsigned CHW  = rwmf_pkg::CHAN_W;
  localparam int unsigned PXW  = rwmf_pkg::PIX_W;
  localparam int unsigned SIDE = rwmf_pkg::WIN_SIDE;
  localparam int unsigned SIZE = rwmf_pkg::WIN_SIZE;
  localparam int unsigned CTR  = rwmf_pkg::CENTER_IDX;

  typedef logic [NCH-1:0][CHW-1:0] rgb_t;   // red in bits 7:0

  typedef struct packed {
    logic full_reload;
    rgb_t chan;
  } pixel_req_t;

  logic           clk_i     = 1'b0;
  logic           rst_ni    = 1'b0;
  logic           s_tvalid  = 1'b0;
  logic [PXW-1:0] s_tdata   = '0;
  logic           s_tuser   = 1'b0;
  logic           m_tready  = 1'b0;
  logic           cfg_we    = 1'b0;
  logic           cfg_wdata = 1'b0;
  wire            s_tready;
  wire            m_tvalid;
  wire  [PXW-1:0] m_tdata;

  // window predictor state
  logic [CHW-1:0] win_q [NCH][SIZE];
  int unsigned    grp_count = 0;
  logic           grp_full  = 1'b0;
  logic           pred_mode = rwmf_pkg::MODE_MEDIAN;

  pixel_req_t pixel_q [$];
  rgb_t       filtered_q [$];
  pixel_req_t cur_req;

  int unsigned src_idle_pct   = 0;
  int unsigned sink_stall_pct = 0;
  int unsigned n_requests     = 0;
  int unsigned n_results      = 0;
  int unsigned n_full_groups  = 0;
  int unsigned n_col_groups   = 0;
  int unsigned n_errors       = 0;
  int unsigned idle_cycles    = 0;

  string chan_name [NCH] = '{"red_out", "green_out", "blue_out"};

  rgb_window_median_mean_filter u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_tvalid),
    .s_axis_tready_o(s_tready),
    .s_axis_tdata_i (s_tdata),
    .s_axis_tuser_i (s_tuser),
    .m_axis_tvalid_o(m_tvalid),
    .m_axis_tready_i(m_tready),
    .m_axis_tdata_o (m_tdata),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (cfg_wdata)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  initial begin
    for (int c = 0; c < NCH; c++)
      for (int i = 0; i < SIZE; i++)
        win_q[c][i] = '0;
  end

  function automatic logic [CHW-1:0] filter_chan(input int c);
    logic [CHW-1:0] v [SIZE];
    logic [CHW-1:0] tmp;
    int unsigned    sum;
    if (pred_mode == rwmf_pkg::MODE_MEAN) begin
      sum = 0;
      for (int i = 0; i < SIZE; i++)
        sum += win_q[c][i] * ((i == CTR) ? 2 : 1);
      return CHW'(sum / MEAN_DIV);
    end
    for (int i = 0; i < SIZE; i++)
      v[i] = win_q[c][i];
    for (int i = 0; i < SIZE - 1; i++)
      for (int j = 0; j < SIZE - 1 - i; j++)
        if (v[j] > v[j+1]) begin
          tmp    = v[j];
          v[j]   = v[j+1];
          v[j+1] = tmp;
        end
    return v[CTR];
  endfunction

  task automatic absorb_pixel(input pixel_req_t p);
    int unsigned needed;
    rgb_t        res;
    if (grp_count == 0) begin
      grp_full = p.full_reload;
      if (grp_full) begin
        n_full_groups++;
      end else begin
        n_col_groups++;
        for (int c = 0; c < NCH; c++)
          for (int r = 0; r < SIDE; r++) begin
            win_q[c][r*SIDE]   = win_q[c][r*SIDE+1];
            win_q[c][r*SIDE+1] = win_q[c][r*SIDE+2];
          end
      end
    end
    needed = grp_full ? SIZE : SIDE;
    for (int c = 0; c < NCH; c++)
      if (grp_full)
        win_q[c][grp_count] = p.chan[c];
      else
        win_q[c][grp_count*SIDE+2] = p.chan[c];
    grp_count++;
    if (grp_count == needed) begin
      grp_count = 0;
      for (int c = 0; c < NCH; c++)
        res[c] = filter_chan(c);
      filtered_q.push_back(res);
    end
  endtask

  task automatic check_result(input rgb_t got);
    rgb_t exp_pix;
    n_results++;
    if (filtered_q.size() == 0) begin
      if (n_errors < MAX_REPORTS)
        $error("unexpected result %h", got);
      n_errors++;
    end else begin
      exp_pix = filtered_q.pop_front();
      for (int c = 0; c < NCH; c++)
        if (got[c] !== exp_pix[c]) begin
          if (n_errors < MAX_REPORTS)
            $error("%s: expected %0d, got %0d", chan_name[c], exp_pix[c], got[c]);
          n_errors++;
        end
    end
  endtask

  // pixel request driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        absorb_pixel(cur_req);
        n_requests++;
      end
      if (!s_tvalid || s_tready) begin
        if (pixel_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
          cur_req = pixel_q.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= cur_req.chan;
          s_tuser  <= cur_req.full_reload;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready)
        check_result(m_tdata);
      m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no request moved for %0d cycles", WATCHDOG_LIMIT);
      $display("FAIL");
      $finish;
    end
  end

  task automatic push_pixel(input logic fr, input logic [7:0] r, input logic [7:0] g,
                            input logic [7:0] b);
    pixel_req_t p;
    p.full_reload = fr;
    p.chan        = {b, g, r};
    pixel_q.push_back(p);
  endtask

  task automatic wait_idle();
    while (pixel_q.size() != 0 || s_tvalid || filtered_q.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_mode(input logic m);
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= m;
    pred_mode = m;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
  endtask

  function automatic logic [7:0] rand_level(input logic [7:0] base);
    case ($urandom_range(9))
      0:       return 8'h00;
      1:       return 8'hFF;
      2, 3:    return base + 8'($urandom_range(3));   // clustered, gives ties
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  initial begin
    int unsigned n;
    int unsigned len;
    logic        full;
    logic [7:0]  base;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    write_mode(rwmf_pkg::MODE_MEDIAN);

    // column group on the zero window left by reset
    push_pixel(1'b0, 8'hFF, 8'h00, 8'hA5);
    push_pixel(1'b0, 8'h5A, 8'hFF, 8'h01);
    push_pixel(1'b0, 8'h80, 8'h7F, 8'hFE);
    // full reload, flags inside the group are ignored
    push_pixel(1'b1, 8'h00, 8'hFF, 8'h00);
    push_pixel(1'b0, 8'hFF, 8'h00, 8'hFF);
    push_pixel(1'b1, 8'hAA, 8'h55, 8'hAA);
    push_pixel(1'b0, 8'h55, 8'hAA, 8'h55);
    push_pixel(1'b0, 8'hFF, 8'hFF, 8'hFF);
    push_pixel(1'b1, 8'h00, 8'h00, 8'h00);
    push_pixel(1'b0, 8'h01, 8'h80, 8'h7F);
    push_pixel(1'b0, 8'hFE, 8'h7F, 8'h80);
    push_pixel(1'b0, 8'h80, 8'h80, 8'h80);
    // column group, flag high inside the group is ignored
    push_pixel(1'b0, 8'h10, 8'hF0, 8'h0F);
    push_pixel(1'b1, 8'h20, 8'hE0, 8'hFF);
    push_pixel(1'b1, 8'hFF, 8'h00, 8'h00);
    wait_idle();

    write_mode(rwmf_pkg::MODE_MEAN);
    for (int k = 0; k < SIZE; k++)
      push_pixel(k == 0, 8'hFF, 8'hFF, 8'hFF);
    // mode change with one pixel of a column group taken
    push_pixel(1'b0, 8'h00, 8'h12, 8'hFF);
    wait_idle();
    write_mode(rwmf_pkg::MODE_MEDIAN);
    push_pixel(1'b0, 8'h00, 8'h34, 8'hFF);
    push_pixel(1'b0, 8'h00, 8'h56, 8'hFF);
    wait_idle();

    for (int p = 0; p < NUM_PHASES; p++) begin
      write_mode(1'((p + p / 4) % 2));
      case (p % 4)
        0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin src_idle_pct = 55; sink_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  sink_stall_pct = 55; end
        default: begin src_idle_pct = 7; sink_stall_pct = 7; end
      endcase
      n = 0;
      while (n < PHASE_ITEMS) begin
        full = ($urandom_range(99) < 30);
        len  = full ? SIZE : SIDE;
        if ($urandom_range(99) < 5)
          len = $urandom_range(len, 1);   // broken group, runs on into the next
        base = 8'($urandom_range(255));
        for (int k = 0; k < len; k++)
          push_pixel((k == 0) ? full : 1'($urandom_range(1)),
                     rand_level(base), rand_level(base), rand_level(base));
        n += len;
      end
      wait_idle();
    end

    $display("Ran %0d pixel requests (%0d full reloads, %0d column groups) in both modes",
             n_requests, n_full_groups, n_col_groups);
    $display("under four backpressure mixes; %0d filtered pixels checked, %0d mismatches.",
             n_results, n_errors);
    if (n_errors == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
